/* hdl/mre_pkg.sv */
// Package for the R-type execute block: funct codes, widths, shared types.
// No dependencies.
`timescale 1ns / 1ps
package mre_pkg;
  localparam int unsigned XLEN      = 32;
  localparam int unsigned NREGS     = 32;
  localparam int unsigned RIDX_W    = 5;
  localparam logic [31:0] PC_STEP   = 32'd4;
  localparam logic [31:0] EXIT_CODE = 32'd10;
  localparam int unsigned MD_CNT_W  = 6;

  localparam logic [5:0] FN_SLL = 6'h00, FN_SRL = 6'h02, FN_SRA = 6'h03;
  localparam logic [5:0] FN_SLLV = 6'h04, FN_SRLV = 6'h06, FN_SRAV = 6'h07;
  localparam logic [5:0] FN_JR = 6'h08, FN_JALR = 6'h09, FN_SYSCALL = 6'h0c;
  localparam logic [5:0] FN_MFHI = 6'h10, FN_MTHI = 6'h11;
  localparam logic [5:0] FN_MFLO = 6'h12, FN_MTLO = 6'h13;
  localparam logic [5:0] FN_MULT = 6'h18, FN_MULTU = 6'h19;
  localparam logic [5:0] FN_DIV = 6'h1a, FN_DIVU = 6'h1b;
  localparam logic [5:0] FN_ADD = 6'h20, FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB = 6'h22, FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND = 6'h24, FN_OR = 6'h25;
  localparam logic [5:0] FN_XOR = 6'h26, FN_NOR = 6'h27;
  localparam logic [5:0] FN_SLT = 6'h2a, FN_SLTU = 6'h2b;

  // input transaction payload
  typedef struct packed {
    logic [31:0] instruction;
  } instr_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture instruction, read operands
    logic exec;    // ops other than multiply/divide: commit
    logic md_start;
    logic md_step;
    logic md_done; // commit multiply/divide
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_md;
    logic md_last;
    logic halted;
  } sts_t;
endpackage

/* hdl/mre_stream_if.sv */
// Valid/ready stream interface with a generic payload type.
// Depends on nothing.
`timescale 1ns / 1ps
interface mre_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/mre_ctrl.sv */
// Controller state machine of the execute block.
// Depends on mre_pkg.
`timescale 1ns / 1ps
module mre_ctrl import mre_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DEC  = 4'b0010,
    ST_MD   = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // accept when idle, or when the held result leaves this cycle
  assign in_ready_o  = (state_q == ST_IDLE) || (state_q == ST_OUT && out_ready_i);
  assign out_valid_o = (state_q == ST_OUT);

  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    cmd_o.load = in_valid_i && in_ready_o;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DEC;
      end
      ST_DEC: begin
        if (sts_i.is_md && !sts_i.halted) begin
          cmd_o.md_start = 1'b1;
          state_d = ST_MD;
        end else begin
          cmd_o.exec = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_MD: begin
        cmd_o.md_step = 1'b1;
        if (sts_i.md_last) begin
          cmd_o.md_done = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready_i) state_d = in_valid_i ? ST_DEC : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end
endmodule

/* hdl/mre_datapath.sv */
// Datapath: register file, PC, HI/LO, ALU and a radix-2 multiply/divide unit.
// Depends on mre_pkg.
`timescale 1ns / 1ps
module mre_datapath import mre_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [31:0] instruction_i,
  output logic [31:0] next_pc_o,
  output logic        halted_o,
  output logic        reg_written_o,
  output logic [4:0]  dest_index_o,
  output logic [31:0] dest_value_o,
  output logic [31:0] hi_value_o,
  output logic [31:0] lo_value_o
);
  logic [31:0] rf_q [NREGS];
  logic [31:0] ins_q, a_q, b_q, r2_q;
  logic [31:0] pc_q, hi_q, lo_q;
  logic        run_q;
  logic [31:0] dval_q;
  logic        wr_q;
  logic [4:0]  didx_q;

  // multiply/divide unit state
  logic [63:0] acc_q;      // mult: {hi,lo} product; div: {rem,quot}
  logic [31:0] mb_q;       // multiplicand / divisor magnitude
  logic [MD_CNT_W-1:0] cnt_q;
  logic        neg_q, nega_q, isdiv_q, skip_q;

  logic [5:0]  fn;
  logic [4:0]  rs, rt, rd, sh;
  logic        rtype;
  assign fn    = ins_q[5:0];
  assign sh    = ins_q[10:6];
  assign rd    = ins_q[15:11];
  assign rtype = (ins_q[31:26] == 6'd0);
  assign rs    = instruction_i[25:21];
  assign rt    = instruction_i[20:16];

  assign sts_o.is_md   = rtype && (fn == FN_MULT || fn == FN_MULTU ||
                                   fn == FN_DIV  || fn == FN_DIVU);
  assign sts_o.md_last = (cnt_q == MD_CNT_W'(XLEN - 1));
  assign sts_o.halted  = !run_q;

  // ALU
  logic        wr_c;
  logic [31:0] dval_c, npc_c;
  logic        halt_c;
  always_comb begin
    wr_c   = 1'b0;
    dval_c = '0;
    npc_c  = pc_q + PC_STEP;
    halt_c = 1'b0;
    if (rtype) begin
      case (fn)
        FN_SLL:  begin wr_c = 1'b1; dval_c = b_q << sh; end
        FN_SRL:  begin wr_c = 1'b1; dval_c = b_q >> sh; end
        FN_SRA:  begin wr_c = 1'b1; dval_c = 32'($signed(b_q) >>> sh); end
        FN_SLLV: begin wr_c = 1'b1; dval_c = b_q << a_q[4:0]; end
        FN_SRLV: begin wr_c = 1'b1; dval_c = b_q >> a_q[4:0]; end
        FN_SRAV: begin wr_c = 1'b1; dval_c = 32'($signed(b_q) >>> a_q[4:0]); end
        FN_JR:   npc_c = a_q;
        FN_JALR: begin npc_c = a_q; wr_c = 1'b1; dval_c = pc_q + PC_STEP; end
        FN_SYSCALL: halt_c = (r2_q == EXIT_CODE);
        FN_MFHI: begin wr_c = 1'b1; dval_c = hi_q; end
        FN_MFLO: begin wr_c = 1'b1; dval_c = lo_q; end
        FN_ADD, FN_ADDU: begin wr_c = 1'b1; dval_c = a_q + b_q; end
        FN_SUB, FN_SUBU: begin wr_c = 1'b1; dval_c = a_q - b_q; end
        FN_AND:  begin wr_c = 1'b1; dval_c = a_q & b_q; end
        FN_OR:   begin wr_c = 1'b1; dval_c = a_q | b_q; end
        FN_XOR:  begin wr_c = 1'b1; dval_c = a_q ^ b_q; end
        FN_NOR:  begin wr_c = 1'b1; dval_c = ~(a_q | b_q); end
        FN_SLT:  begin wr_c = 1'b1; dval_c = {31'd0, $signed(a_q) < $signed(b_q)}; end
        FN_SLTU: begin wr_c = 1'b1; dval_c = {31'd0, a_q < b_q}; end
        default: ;
      endcase
    end
    if (rd == 5'd0) wr_c = 1'b0;
  end

  // operand signs for multiply/divide
  logic        sgn, na, nb;
  logic [31:0] ma, mb;
  assign sgn = (fn == FN_MULT) || (fn == FN_DIV);
  assign na  = sgn && a_q[31];
  assign nb  = sgn && b_q[31];
  assign ma  = na ? (32'd0 - a_q) : a_q;
  assign mb  = nb ? (32'd0 - b_q) : b_q;

  // one step: shift-add multiply (LSB first) or restoring divide
  logic [63:0] acc_step;
  logic [32:0] dtrial;
  logic [32:0] madd;
  always_comb begin
    madd   = {1'b0, acc_q[63:32]} + (acc_q[0] ? {1'b0, mb_q} : 33'd0);
    dtrial = {acc_q[63:31]} - {1'b0, mb_q};
    if (isdiv_q) begin
      if (!dtrial[32]) acc_step = {dtrial[31:0], acc_q[30:0], 1'b1};
      else             acc_step = {acc_q[62:0], 1'b0};
    end else begin
      acc_step = {madd, acc_q[31:1]};
    end
  end

  logic [63:0] prod;
  logic [31:0] quo, rem;
  assign prod = neg_q ? (64'd0 - acc_step) : acc_step;
  assign quo  = neg_q ? (32'd0 - acc_step[31:0]) : acc_step[31:0];
  assign rem  = nega_q ? (32'd0 - acc_step[63:32]) : acc_step[63:32];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ins_q <= instruction_i;
      a_q   <= rf_q[rs];
      b_q   <= rf_q[rt];
      r2_q  <= rf_q[2];
    end
    if (cmd_i.md_start) begin
      mb_q    <= mb;
      acc_q   <= {32'd0, ma};
      isdiv_q <= (fn == FN_DIV) || (fn == FN_DIVU);
      neg_q   <= na ^ nb;
      nega_q  <= na;
      skip_q  <= ((fn == FN_DIV) || (fn == FN_DIVU)) && (b_q == 32'd0);
      cnt_q   <= '0;
    end else if (cmd_i.md_step) begin
      acc_q <= acc_step;
      cnt_q <= cnt_q + MD_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NREGS; i++) rf_q[i] <= '0;
      pc_q  <= '0;
      hi_q  <= '0;
      lo_q  <= '0;
      run_q <= 1'b1;
      wr_q  <= 1'b0;
      didx_q <= '0;
      dval_q <= '0;
    end else if (cmd_i.exec) begin
      if (run_q) begin
        pc_q <= npc_c;
        if (wr_c) rf_q[rd] <= dval_c;
        if (rtype && fn == FN_MTHI) hi_q <= a_q;
        if (rtype && fn == FN_MTLO) lo_q <= a_q;
        if (halt_c) run_q <= 1'b0;
      end
      wr_q   <= run_q && wr_c;
      didx_q <= (run_q && wr_c) ? rd : 5'd0;
      dval_q <= (run_q && wr_c) ? dval_c : 32'd0;
    end else if (cmd_i.md_done) begin
      pc_q   <= pc_q + PC_STEP;
      wr_q   <= 1'b0;
      didx_q <= '0;
      dval_q <= '0;
      if (!isdiv_q) begin
        hi_q <= prod[63:32];
        lo_q <= prod[31:0];
      end else if (!skip_q) begin
        hi_q <= rem;
        lo_q <= quo;
      end
    end
  end

  assign next_pc_o     = pc_q;
  assign halted_o      = !run_q;
  assign reg_written_o = wr_q;
  assign dest_index_o  = didx_q;
  assign dest_value_o  = dval_q;
  assign hi_value_o    = hi_q;
  assign lo_value_o    = lo_q;
endmodule

/* hdl/mips_rtype_execute.sv */
// Top level of the MIPS32 R-type execute block: controller plus datapath.
// Depends on mre_pkg, mre_stream_if, mre_ctrl, mre_datapath.
//
//  channel | direction | payload
//  in_if   | sink      | instruction[31:0]
//  out_if  | source    | next_pc, halted, reg_written, dest_index, dest_value,
//          |           | hi_value, lo_value
//
// Steps per instruction: accept, then decode/execute; MULT/MULTU/DIV/DIVU also
// run the multiply/divide unit, which handles one bit per cycle.
// Reset (rst_ni low) clears the register file, PC, HI, LO and re-arms execution.
// A new transaction is taken in the same cycle the held result is taken.
// Output stalls hold the result register and block input.
`timescale 1ns / 1ps
module mips_rtype_execute import mre_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  mre_stream_if.sink   in_if,
  mre_stream_if.source out_if
);
  cmd_t cmd;
  sts_t sts;

  // control: one transaction in flight at a time
  mre_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // architectural state and execution units
  mre_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .instruction_i (in_if.data.instruction),
    .next_pc_o     (out_if.data.next_pc),
    .halted_o      (out_if.data.halted),
    .reg_written_o (out_if.data.reg_written),
    .dest_index_o  (out_if.data.dest_index),
    .dest_value_o  (out_if.data.dest_value),
    .hi_value_o    (out_if.data.hi_value),
    .lo_value_o    (out_if.data.lo_value)
  );

  // r0 is never reported as written
  a_no_r0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.data.reg_written |-> out_if.data.dest_index != 5'd0)
    else $error("r0 reported as destination");
  // once halted, stays halted
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(out_if.data.halted) |-> out_if.data.halted)
    else $error("halt released without reset");
  // never accept while multiply/divide runs
  a_no_accept_md: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.md_step |-> !in_if.ready)
    else $error("input accepted during multiply/divide");
endmodule

/* tb/mips_rtype_execute_tb.sv */
// Self-checking testbench for the MIPS32 R-type execute block.
// Depends on mre_pkg, mre_stream_if and mips_rtype_execute. A class predicts
// each result and plain tasks drive the instruction stream.
`timescale 1ns / 1ps
module mips_rtype_execute_tb;
  import mre_pkg::*;

  // Result payload, most significant field first.
  typedef struct packed {
    logic [31:0] next_pc;
    logic        halted;
    logic        reg_written;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic [31:0] hi_value;
    logic [31:0] lo_value;
  } result_t;

  localparam int unsigned CYCLE_LIMIT = 800000;
  localparam int unsigned N_RANDOM    = 1030;

  // Golden copy of the architectural state, plus the queue of pending results.
  class exec_scoreboard;
    logic [31:0] regs [NREGS];
    logic [31:0] pc, hi, lo;
    bit          running;
    result_t     pending [$];
    int unsigned errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      pc = '0; hi = '0; lo = '0;
      running = 1'b1;
      errors = 0;
    endfunction

    function logic [31:0] shift_ra(logic [31:0] v, logic [4:0] s);
      return $unsigned($signed(v) >>> s);
    endfunction

    // Execute one accepted instruction and queue its result.
    function void note_instruction(logic [31:0] ins);
      result_t     r;
      logic [31:0] a, b, npc, dval, ma, mb, q, rm;
      logic [5:0]  fn;
      logic [4:0]  rd, sh;
      logic [63:0] p;
      bit          wr, na, nb;
      wr = 1'b0;
      dval = '0;
      rd = ins[15:11];
      if (running) begin
        fn = ins[5:0];
        a = regs[ins[25:21]];
        b = regs[ins[20:16]];
        sh = ins[10:6];
        npc = pc + PC_STEP;
        if (ins[31:26] == 6'd0) begin
          case (fn)
            FN_SLL:  begin wr = 1; dval = b << sh; end
            FN_SRL:  begin wr = 1; dval = b >> sh; end
            FN_SRA:  begin wr = 1; dval = shift_ra(b, sh); end
            FN_SLLV: begin wr = 1; dval = b << a[4:0]; end
            FN_SRLV: begin wr = 1; dval = b >> a[4:0]; end
            FN_SRAV: begin wr = 1; dval = shift_ra(b, a[4:0]); end
            FN_JR:   npc = a;
            FN_JALR: begin npc = a; wr = 1; dval = pc + PC_STEP; end
            FN_SYSCALL: if (regs[2] == EXIT_CODE) running = 1'b0;
            FN_MFHI: begin wr = 1; dval = hi; end
            FN_MTHI: hi = a;
            FN_MFLO: begin wr = 1; dval = lo; end
            FN_MTLO: lo = a;
            FN_MULT: begin
              p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
              hi = p[63:32]; lo = p[31:0];
            end
            FN_MULTU: begin
              p = {32'd0, a} * {32'd0, b};
              hi = p[63:32]; lo = p[31:0];
            end
            FN_DIV: if (b != 0) begin
              na = a[31]; nb = b[31];
              ma = na ? -a : a;
              mb = nb ? -b : b;
              q = ma / mb;
              rm = ma % mb;
              lo = (na != nb) ? -q : q;
              hi = na ? -rm : rm;
            end
            FN_DIVU: if (b != 0) begin
              lo = a / b; hi = a % b;
            end
            FN_ADD, FN_ADDU: begin wr = 1; dval = a + b; end
            FN_SUB, FN_SUBU: begin wr = 1; dval = a - b; end
            FN_AND:  begin wr = 1; dval = a & b; end
            FN_OR:   begin wr = 1; dval = a | b; end
            FN_XOR:  begin wr = 1; dval = a ^ b; end
            FN_NOR:  begin wr = 1; dval = ~(a | b); end
            FN_SLT:  begin wr = 1; dval = {31'd0, $signed(a) < $signed(b)}; end
            FN_SLTU: begin wr = 1; dval = {31'd0, a < b}; end
            default: ;
          endcase
        end
        if (wr && rd == 0) wr = 1'b0;
        if (wr) regs[rd] = dval;
        pc = npc;
      end
      r.next_pc     = pc;
      r.halted      = !running;
      r.reg_written = wr;
      r.dest_index  = wr ? rd : 5'd0;
      r.dest_value  = wr ? dval : 32'd0;
      r.hi_value    = hi;
      r.lo_value    = lo;
      pending.push_back(r);
    endfunction

    // Compare one accepted result against the oldest prediction.
    function void check_result(result_t got);
      result_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result transaction: %p", got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.next_pc !== exp_r.next_pc) begin
        $error("next_pc: expected %h, actual %h", exp_r.next_pc, got.next_pc); errors++;
      end
      if (got.halted !== exp_r.halted) begin
        $error("halted: expected %b, actual %b", exp_r.halted, got.halted); errors++;
      end
      if (got.reg_written !== exp_r.reg_written) begin
        $error("reg_written: expected %b, actual %b", exp_r.reg_written, got.reg_written);
        errors++;
      end
      if (got.dest_index !== exp_r.dest_index) begin
        $error("dest_index: expected %0d, actual %0d", exp_r.dest_index, got.dest_index);
        errors++;
      end
      if (got.dest_value !== exp_r.dest_value) begin
        $error("dest_value: expected %h, actual %h", exp_r.dest_value, got.dest_value);
        errors++;
      end
      if (got.hi_value !== exp_r.hi_value) begin
        $error("hi_value: expected %h, actual %h", exp_r.hi_value, got.hi_value); errors++;
      end
      if (got.lo_value !== exp_r.lo_value) begin
        $error("lo_value: expected %h, actual %h", exp_r.lo_value, got.lo_value); errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  mre_stream_if #(.T(instr_t))  in_if ();
  mre_stream_if #(.T(result_t)) out_if ();

  mips_rtype_execute u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  exec_scoreboard sb = new();

  // Idle rates in percent; the sequencer switches them per phase.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Drop the run if it hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: check each transaction, then pick the next ready level.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Build an R-type word from its fields.
  function automatic logic [31:0] rtype(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                        logic [4:0] sh, logic [5:0] fn);
    return {6'd0, rs, rt, rd, sh, fn};
  endfunction

  // Present one instruction, hold it until the transaction completes, then predict.
  task automatic send_instruction(logic [31:0] ins);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data.instruction <= ins;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_instruction(ins);
  endtask

  // Hold the sender until every predicted result has been taken.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  // Random instruction, mostly legal R-type with random operands.
  function automatic logic [31:0] random_instruction();
    logic [5:0] fns [27] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR,
      FN_JALR, FN_SYSCALL, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT, FN_MULTU,
      FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR,
      FN_NOR, FN_SLT, FN_SLTU};
    logic [31:0] w;
    int unsigned pick;
    w = $urandom;
    pick = $urandom_range(99);
    if (pick < 5) begin
      if (w[31:26] == 6'd0) w[31:26] = 6'd1;
    end else if (pick < 10) begin
      w[31:26] = 6'd0;
    end else begin
      w[31:26] = 6'd0;
      w[5:0] = fns[$urandom_range(26)];
    end
    // Keep the exit for the end of the run: a halt here would end checking.
    if (w[31:26] == 6'd0 && w[5:0] == FN_SYSCALL && sb.regs[2] == EXIT_CODE)
      w[5:0] = FN_ADDU;
    return w;
  endfunction

  initial begin
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    send_idle_pct = 14;
    recv_idle_pct = 49;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: constants, shift extremes, overflow, divide corners, jumps.
    send_instruction(rtype(0, 0, 3, 0, FN_NOR));          // r3 = all ones
    send_instruction(rtype(0, 3, 4, 31, FN_SRL));         // r4 = 1
    send_instruction(rtype(0, 4, 5, 31, FN_SLL));         // r5 = 0x80000000
    send_instruction(rtype(0, 5, 6, 31, FN_SRA));         // r6 = all ones
    send_instruction(rtype(0, 5, 7, 0, FN_SRA));          // shift by zero
    send_instruction(rtype(3, 4, 8, 0, FN_SLLV));         // amount from low 5 bits
    send_instruction(rtype(3, 5, 9, 0, FN_SRAV));
    send_instruction(rtype(3, 5, 10, 0, FN_SRLV));
    send_instruction(rtype(3, 4, 11, 0, FN_ADD));         // wraps to zero
    send_instruction(rtype(5, 4, 12, 0, FN_SUB));         // wraps to 0x7fffffff
    send_instruction(rtype(5, 3, 0, 0, FN_ADDU));         // write to r0 dropped
    send_instruction(rtype(5, 4, 13, 0, FN_SLT));
    send_instruction(rtype(5, 4, 14, 0, FN_SLTU));
    send_instruction(rtype(5, 3, 0, 0, FN_DIV));          // min by -1
    send_instruction(rtype(5, 0, 0, 0, FN_DIV));          // divide by zero
    send_instruction(rtype(3, 0, 0, 0, FN_DIVU));
    send_instruction(rtype(3, 3, 0, 0, FN_MULT));
    send_instruction(rtype(3, 3, 0, 0, FN_MULTU));
    send_instruction(rtype(0, 0, 15, 0, FN_MFHI));
    send_instruction(rtype(0, 0, 16, 0, FN_MFLO));
    send_instruction(rtype(12, 0, 0, 0, FN_MTHI));
    send_instruction(rtype(3, 0, 0, 0, FN_MTLO));
    send_instruction(rtype(0, 0, 0, 0, FN_SYSCALL));      // r2 != exit code
    send_instruction(rtype(3, 0, 17, 0, FN_JALR));        // unaligned target, link
    send_instruction(rtype(17, 0, 0, 0, FN_JR));
    send_instruction({6'h3f, 26'h3ffffff});               // non-R-type opcode
    send_instruction(rtype(0, 0, 0, 0, 6'h3f));           // unknown funct
    drain_results();

    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) begin
        send_idle_pct = 49;
        recv_idle_pct = 14;
      end else if (i == 2 * N_RANDOM / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (i == N_RANDOM / 2) drain_results();
      send_instruction(random_instruction());
    end

    // Load the exit code into r2 and halt, then check that items are ignored.
    send_instruction(rtype(0, 0, 3, 0, FN_NOR));
    send_instruction(rtype(0, 3, 3, 31, FN_SRL));
    send_instruction(rtype(0, 3, 4, 3, FN_SLL));
    send_instruction(rtype(0, 3, 5, 1, FN_SLL));
    send_instruction(rtype(4, 5, 2, 0, FN_ADD));
    send_instruction(rtype(0, 0, 0, 0, FN_SYSCALL));
    for (int unsigned i = 0; i < 4; i++) send_instruction(random_instruction());
    in_if.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

/* filelist.f */
hdl/mre_pkg.sv
hdl/mre_stream_if.sv
hdl/mre_ctrl.sv
hdl/mre_datapath.sv
hdl/mips_rtype_execute.sv
tb/mips_rtype_execute_tb.sv
